// ----- sv/damped_point_smoother_table_defines.svh -----
// Assertion macros shared by the checker.
`ifndef DAMPED_POINT_SMOOTHER_TABLE_DEFINES_SVH
`define DAMPED_POINT_SMOOTHER_TABLE_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define DPS_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) else $error(msg);
// Assert that a condition implies a consequence in the next cycle.
`define DPS_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) else $error(msg);
`endif

// ----- sv/dps_pkg.sv -----
// Package: widths, constants and fixed-point helpers for the point smoother.
`default_nettype none
package dps_pkg;
    localparam int GROUPS_DEF = 16;
    localparam int TREES_DEF  = 512;
    localparam logic [1:0] CFG_TIME   = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;
    localparam logic signed [63:0] ONE_Q16   = 64'sd65536;
    localparam logic signed [63:0] LIMIT_Q16 = 64'sd65536000;
    localparam logic [23:0] SNAP_ABOVE = 24'd655360;
    localparam logic signed [17:0] BLEND_BELOW = 18'sd66;
    localparam logic [2:0] MODE_PASS  = 3'd0;
    localparam logic [2:0] MODE_INIT  = 3'd1;
    localparam logic [2:0] MODE_SNAP  = 3'd2;
    localparam logic [2:0] MODE_BLEND = 3'd3;
    localparam logic [2:0] MODE_DAMP  = 3'd4;

    function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int n);
        logic signed [63:0] t;
        t = v + (64'sd1 <<< (n - 1));
        return t >>> n;
    endfunction

    function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
        input logic signed [63:0] lo, input logic signed [63:0] hi);
        logic signed [63:0] r;
        r = v;
        if (v < lo) r = lo;
        if (v > hi) r = hi;
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- sv/dps_ram.sv -----
// Generic synchronous RAM with one write port, one read port and registered read.
`default_nettype none
module dps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- sv/damped_point_smoother_table.sv -----
// Top level: table-based damped 2D point smoother.
// A request is taken when start is high and busy is low; busy then rises. An
// update passes READ, DEC, M1-M4 and OUT to its one-cycle done strobe (memory
// read, then a chain of registered multiplies per axis); a clear writes all
// GROUPS*2*TREES entries, one entry per cycle, and gives no result. After
// reset the same sweep runs first. Results are never held off by the receiver.
`default_nettype none
module damped_point_smoother_table #(
    parameter int GROUPS = dps_pkg::GROUPS_DEF,
    parameter int TREES  = dps_pkg::TREES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [23:0]        cfg_data,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               cmd,
    input  wire logic [7:0]         group,
    input  wire logic [13:0]        tree_index,
    input  wire logic               side,
    input  wire logic signed [31:0] target_x,
    input  wire logic signed [31:0] target_y,
    input  wire logic [16:0]        softness,
    input  wire logic signed [17:0] follow_weight,
    output logic                    done,
    output logic signed [31:0]      point_x,
    output logic signed [31:0]      point_y,
    output logic signed [31:0]      speed_x,
    output logic signed [31:0]      speed_y
);
    import dps_pkg::*;
    localparam int ENTRIES = GROUPS * 2 * TREES;
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int TW = (TREES > 1) ? $clog2(TREES) : 1;
    localparam int MW = 129;  // valid + pos x/y + vel x/y

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_READ  = 4'd2;
    localparam logic [3:0] ST_DEC   = 4'd3;
    localparam logic [3:0] ST_M1    = 4'd4;
    localparam logic [3:0] ST_M2    = 4'd5;
    localparam logic [3:0] ST_M3    = 4'd6;
    localparam logic [3:0] ST_M4    = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [AW:0] sweep_reg;
    logic [23:0] tf_reg;
    logic [13:0] sw_reg, sh_reg;

    logic [AW-1:0] addr_reg;
    logic          inr_reg;
    logic signed [31:0] tx_reg, ty_reg;
    logic [16:0] s_reg;
    logic signed [17:0] w_reg;
    logic [2:0] mode_reg;

    logic signed [31:0] px_reg, py_reg, vx_reg, vy_reg;
    logic signed [63:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [40:0] k_reg;

    logic          we;
    logic [AW-1:0] waddr;
    logic [MW-1:0] wdata, rdata;

    dps_ram #(.WIDTH(MW), .DEPTH(ENTRIES)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(addr_reg), .rdata(rdata)
    );

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        we = 1'b0;
        waddr = addr_reg;
        wdata = {1'b1, px_reg, py_reg, vx_reg, vy_reg};
        if (state_reg == ST_CLEAR)
        begin
            we = 1'b1;
            waddr = sweep_reg[AW-1:0];
            wdata = '0;
        end
        else if (state_reg == ST_OUT && inr_reg)
        begin
            we = 1'b1;
        end
    end

    // Per-axis damped-step helpers over registered values.
    logic signed [63:0] one_m_s, gain;
    logic signed [63:0] sat_vx, sat_vy, stx, sty, npx, npy, hx, hy;
    always_comb
    begin
        one_m_s = ONE_Q16 - $signed({47'd0, s_reg});
        gain = ONE_Q16 - $signed({{46{w_reg[17]}}, w_reg});
        sat_vx = clamp64(bx_reg, -64'sd2147483648, 64'sd2147483647);
        sat_vy = clamp64(by_reg, -64'sd2147483648, 64'sd2147483647);
        stx = clamp64(rnd(ax_reg, 16), -LIMIT_Q16, LIMIT_Q16);
        sty = clamp64(rnd(ay_reg, 16), -LIMIT_Q16, LIMIT_Q16);
        hx = ($signed({50'd0, sw_reg}) + 64'sd1000) <<< 16;
        hy = ($signed({50'd0, sh_reg}) + 64'sd1000) <<< 16;
        npx = clamp64($signed({{32{px_reg[31]}}, px_reg}) + stx, -LIMIT_Q16, hx);
        npy = clamp64($signed({{32{py_reg[31]}}, py_reg}) + sty, -LIMIT_Q16, hy);
    end

    logic signed [63:0] blx, bly;
    assign blx = rnd(bx_reg, 16);
    assign bly = rnd(by_reg, 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            sweep_reg <= '0;
            tf_reg <= 24'd65536;
            sw_reg <= 14'd1920;
            sh_reg <= 14'd1080;
            done <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done <= (state_reg == ST_OUT);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TIME:   tf_reg <= cfg_data;
                    CFG_WIDTH:  sw_reg <= cfg_data[13:0];
                    CFG_HEIGHT: sh_reg <= cfg_data[13:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_CLEAR)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            else if (state_reg == ST_IDLE && start && cmd)
            begin
                sweep_reg <= '0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (sweep_reg == (AW+1)'(ENTRIES - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (start) state_next = cmd ? ST_CLEAR : ST_READ;
            ST_READ:  state_next = ST_DEC;
            ST_DEC:   state_next = ST_M1;
            ST_M1:    state_next = ST_M2;
            ST_M2:    state_next = ST_M3;
            ST_M3:    state_next = ST_M4;
            ST_M4:    state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath: payload registers, no reset.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                inr_reg <= (32'(group) < 32'(GROUPS)) && (32'(tree_index) < 32'(TREES));
                addr_reg <= AW'(((32'(group) * 2 + 32'(side)) * TREES)
                            + 32'(tree_index[TW-1:0]));
                tx_reg <= target_x;
                ty_reg <= target_y;
                s_reg <= (softness > 17'd65536) ? 17'd65536 : softness;
                w_reg <= (follow_weight > 18'sd65536) ? 18'sd65536 : follow_weight;
            end
            ST_DEC:
            begin
                px_reg <= rdata[127:96];
                py_reg <= rdata[95:64];
                vx_reg <= rdata[63:32];
                vy_reg <= rdata[31:0];
                k_reg <= 41'(s_reg) * 41'(tf_reg);
                if (!inr_reg) mode_reg <= MODE_PASS;
                else if (!rdata[128]) mode_reg <= MODE_INIT;
                else if (tf_reg > SNAP_ABOVE) mode_reg <= MODE_SNAP;
                else if (w_reg < BLEND_BELOW) mode_reg <= MODE_BLEND;
                else mode_reg <= MODE_DAMP;
            end
            ST_M1:
            begin
                // blend products or decayed velocity products
                if (mode_reg == MODE_BLEND)
                begin
                    ax_reg <= $signed({{32{tx_reg[31]}}, tx_reg}) * one_m_s
                            + $signed({{32{px_reg[31]}}, px_reg}) * $signed({47'd0, s_reg});
                    ay_reg <= $signed({{32{ty_reg[31]}}, ty_reg}) * one_m_s
                            + $signed({{32{py_reg[31]}}, py_reg}) * $signed({47'd0, s_reg});
                end
                else
                begin
                    ax_reg <= $signed({{32{vx_reg[31]}}, vx_reg})
                            * ((64'sd1 <<< 32) - $signed({23'd0, k_reg}));
                    ay_reg <= $signed({{32{vy_reg[31]}}, vy_reg})
                            * ((64'sd1 <<< 32) - $signed({23'd0, k_reg}));
                end
                bx_reg <= ($signed({{32{tx_reg[31]}}, tx_reg})
                         - $signed({{32{px_reg[31]}}, px_reg})) * gain;
                by_reg <= ($signed({{32{ty_reg[31]}}, ty_reg})
                         - $signed({{32{py_reg[31]}}, py_reg})) * gain;
            end
            ST_M2:
            begin
                if (mode_reg == MODE_BLEND)
                begin
                    bx_reg <= ax_reg;
                    by_reg <= ay_reg;
                end
                else if (k_reg > 41'h100000000)
                begin
                    bx_reg <= rnd(bx_reg, 17);
                    by_reg <= rnd(by_reg, 17);
                end
                else if (k_reg != 41'd0)
                begin
                    bx_reg <= rnd(ax_reg, 32) + rnd(bx_reg, 17);
                    by_reg <= rnd(ay_reg, 32) + rnd(by_reg, 17);
                end
                else
                begin
                    bx_reg <= $signed({{32{vx_reg[31]}}, vx_reg}) + rnd(bx_reg, 17);
                    by_reg <= $signed({{32{vy_reg[31]}}, vy_reg}) + rnd(by_reg, 17);
                end
            end
            ST_M3:
            begin
                if (mode_reg == MODE_DAMP)
                begin
                    vx_reg <= sat_vx[31:0];
                    vy_reg <= sat_vy[31:0];
                    ax_reg <= sat_vx * $signed({40'd0, tf_reg});
                    ay_reg <= sat_vy * $signed({40'd0, tf_reg});
                end
            end
            ST_M4:
            begin
                case (mode_reg)
                    MODE_PASS:
                    begin
                        px_reg <= tx_reg; py_reg <= ty_reg;
                        vx_reg <= '0; vy_reg <= '0;
                    end
                    MODE_INIT:
                    begin
                        px_reg <= tx_reg; py_reg <= ty_reg;
                    end
                    MODE_SNAP:
                    begin
                        px_reg <= tx_reg; py_reg <= ty_reg;
                        vx_reg <= '0; vy_reg <= '0;
                    end
                    MODE_BLEND:
                    begin
                        px_reg <= blx[31:0];
                        py_reg <= bly[31:0];
                    end
                    default:
                    begin
                        px_reg <= npx[31:0];
                        py_reg <= npy[31:0];
                    end
                endcase
            end
            ST_OUT:
            begin
                point_x <= px_reg; point_y <= py_reg;
                speed_x <= vx_reg; speed_y <= vy_reg;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ----- sv/dps_checker.sv -----
// Port-level checker for the point smoother, bound to the top level.
`default_nettype none
`include "damped_point_smoother_table_defines.svh"
module dps_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic cmd,
    input wire logic done
);
    `DPS_ASSERT_NEXT(a_take_busy, clk, rst_n, start && !busy, busy, "busy not raised on request")
    `DPS_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "done longer than one cycle")
    `DPS_ASSERT_IMPL(a_done_idle, clk, rst_n, done, !busy, "done while still busy")
    `DPS_ASSERT_NEXT(a_clear_quiet, clk, rst_n, start && !busy && cmd, !done, "result after clear")
endmodule
bind damped_point_smoother_table dps_checker u_dps_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .done(done)
);
`default_nettype wire
